### src/can_bts_pkg.sv
// can_bts_pkg: shared types and constants for the can bit timing solver
// transaction payload structs, configuration register indexes, default parameters
// no dependencies
`default_nettype none

package can_bts_pkg;

    localparam int CLK_W      = 32;
    localparam int RATE_W     = 24;
    localparam int PRE_W      = 11;
    localparam int SJL_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int QUANTA_MAX_DEF = 25;
    localparam int QUANTA_MIN_DEF = 8;

    localparam logic [PRE_W-1:0] PRESCALER_FLOOR_RST = 11'd1;
    localparam logic [SJL_W-1:0] SYNC_JUMP_LIMIT_RST = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESCALER_FLOOR = 2'd0,
        CFG_SYNC_JUMP_LIMIT = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [CLK_W-1:0]  clock_freq;
        logic [RATE_W-1:0] target_rate;
        logic [PRE_W-1:0]  prescaler_ceiling;
    } in_item_t;

    typedef struct packed {
        logic             status;
        logic [PRE_W-1:0] prescaler;
        logic [4:0]       quanta_per_bit;
        logic [4:0]       phase_seg1;
        logic [2:0]       phase_seg2;
        logic [2:0]       jump_width;
    } out_item_t;

    localparam out_item_t ERROR_RESULT = '{
        status: 1'b1, prescaler: '0, quanta_per_bit: '0,
        phase_seg1: '0, phase_seg2: '0, jump_width: '0
    };

endpackage

`default_nettype wire

### src/can_bts_div.sv
// can_bts_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder; uses no package items
`default_nettype none

module can_bts_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 31
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic                  done,
    output logic [NUM_W-1:0]      quotient,
    output logic [DEN_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;

    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(NUM_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end
        else if (run_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### src/can_bts_seq.sv
// can_bts_seq: search sequencer over quanta counts, drives the divider
// and holds the output register; depends on can_bts_pkg
`default_nettype none

module can_bts_seq
    import can_bts_pkg::*;
#(
    parameter int QUANTA_MAX = QUANTA_MAX_DEF,
    parameter int QUANTA_MIN = QUANTA_MIN_DEF,
    parameter int QW         = 5,
    parameter int DW         = RATE_W + 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data,
    input  wire logic [PRE_W-1:0] prescaler_floor,
    input  wire logic [SJL_W-1:0] sync_jump_limit,
    output logic                  div_start,
    output logic [CLK_W-1:0]      div_dividend,
    output logic [DW-1:0]         div_divisor,
    input  wire logic             div_done,
    input  wire logic [CLK_W-1:0] div_quotient,
    input  wire logic [DW-1:0]    div_remainder
);

    localparam int SW = (QW > SJL_W) ? QW : SJL_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CLK_W-1:0]  clk_reg, clk_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [PRE_W-1:0]  ceil_reg, ceil_next;
    logic [QW-1:0]     q_reg, q_next;
    out_item_t         res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic            match;
    logic [QW-1:0]   tm1;
    logic [QW+1:0]   tm1x3;
    logic [QW-1:0]   seg1;
    logic [QW-1:0]   seg2;
    logic [SW-1:0]   sjw;
    out_item_t       found;

    // candidate timing for the current count
    assign tm1   = q_reg - QW'(1);
    assign tm1x3 = (QW+2)'(tm1) + (QW+2)'({tm1, 1'b0});
    assign seg1  = tm1x3[QW+1:2];
    assign seg2  = tm1 - seg1;
    assign sjw   = (SW'(seg2) < SW'(sync_jump_limit)) ? SW'(seg2) : SW'(sync_jump_limit);

    assign match = (div_remainder == '0)
                && (div_quotient >= CLK_W'(prescaler_floor))
                && (div_quotient <= CLK_W'(ceil_reg));

    always_comb
    begin
        found.status         = 1'b0;
        found.prescaler      = div_quotient[PRE_W-1:0];
        found.quanta_per_bit = q_reg[4:0];
        found.phase_seg1     = seg1[4:0];
        found.phase_seg2     = seg2[2:0];
        found.jump_width     = sjw[2:0];
    end

    assign div_start    = (state_reg == ST_LAUNCH);
    assign div_dividend = clk_reg;
    assign div_divisor  = DW'(rate_reg) * DW'(q_reg);

    always_comb
    begin
        state_next     = state_reg;
        clk_next       = clk_reg;
        rate_next      = rate_reg;
        ceil_next      = ceil_reg;
        q_next         = q_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    clk_next  = in_data.clock_freq;
                    rate_next = in_data.target_rate;
                    ceil_next = in_data.prescaler_ceiling;
                    q_next    = QW'(QUANTA_MAX);
                    if (in_data.clock_freq == '0 || in_data.target_rate == '0
                        || QUANTA_MIN > QUANTA_MAX)
                    begin
                        res_next   = ERROR_RESULT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (match)
                    begin
                        res_next   = found;
                        state_next = ST_DONE;
                    end
                    else if (q_reg == QW'(QUANTA_MIN) || q_reg == QW'(1))
                    begin
                        res_next   = ERROR_RESULT;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        q_next     = q_reg - QW'(1);
                        state_next = ST_LAUNCH;
                    end
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clk_reg      <= clk_next;
        rate_reg     <= rate_next;
        ceil_reg     <= ceil_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

### src/can_bit_timing_solver.sv
// can_bit_timing_solver: top level, configuration registers, sequencer and divider
// depends on can_bts_pkg, can_bts_seq, can_bts_div
//
// usage:
//   in channel (in_valid/in_ready/in_data) takes one request per transaction:
//   clock frequency, target bitrate and prescaler ceiling.
//   out channel (out_valid/out_ready/out_data) returns exactly one result per
//   request: status, prescaler, quanta per bit, both time segments, jump width.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes prescaler floor
//   (index 0) or sync jump limit (index 1); cfg_ready is always high.
// search:
//   each quanta count tried costs one multiply of bitrate by count that loads
//   the divider in ST_LAUNCH, then a run of the bit-serial 32-bit divider in
//   ST_DIV. counts are tried from QUANTA_MAX down, up to 18 with default
//   parameters; a zero clock or bitrate answers with an error without dividing.
//   one request is in work at a time; in_ready is high only between requests.
// stall and reset:
//   a finished result waits in the output register while out_ready is low and
//   the next request can already be taken; a second result then holds until
//   the register frees up. reset empties the output, goes idle and sets the
//   prescaler floor to 1 and the sync jump limit to 16.
`default_nettype none

module can_bit_timing_solver
    import can_bts_pkg::*;
#(
    parameter int QUANTA_MAX = QUANTA_MAX_DEF,
    parameter int QUANTA_MIN = QUANTA_MIN_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QW_RAW = $clog2(QUANTA_MAX + 1);
    localparam int QW     = (QW_RAW > 5) ? QW_RAW : 5;
    localparam int DW     = RATE_W + QW;

    logic [PRE_W-1:0] floor_reg;
    logic [SJL_W-1:0] sjl_reg;

    logic             div_start;
    logic [CLK_W-1:0] div_dividend;
    logic [DW-1:0]    div_divisor;
    logic             div_done;
    logic [CLK_W-1:0] div_quotient;
    logic [DW-1:0]    div_remainder;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg <= PRESCALER_FLOOR_RST;
            sjl_reg   <= SYNC_JUMP_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PRESCALER_FLOOR: floor_reg <= cfg_data[PRE_W-1:0];
                CFG_SYNC_JUMP_LIMIT: sjl_reg   <= cfg_data[SJL_W-1:0];
                default:             ;
            endcase
        end
    end

    can_bts_seq #(
        .QUANTA_MAX (QUANTA_MAX),
        .QUANTA_MIN (QUANTA_MIN),
        .QW         (QW),
        .DW         (DW)
    ) u_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .prescaler_floor (floor_reg),
        .sync_jump_limit (sjl_reg),
        .div_start       (div_start),
        .div_dividend    (div_dividend),
        .div_divisor     (div_divisor),
        .div_done        (div_done),
        .div_quotient    (div_quotient),
        .div_remainder   (div_remainder)
    );

    can_bts_div #(
        .NUM_W (CLK_W),
        .DEN_W (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

endmodule

`default_nettype wire
